@@ hdl/fwlp_pkg.sv @@
// ----------------------------------------------------------------------------
// four wheel lateral pid move - shared definitions
// transfer payloads, lane control group, command, status and register codes
// ----------------------------------------------------------------------------
package fwlp_pkg;

	localparam int WHEELS    = 4;
	localparam int DIV_STEPS = 16;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// reset values of the configuration registers
	localparam logic [15:0] GAIN_PROP_RST  = 16'd1;
	localparam logic [14:0] GAIN_DIV_RST   = 15'd1;
	localparam logic [15:0] GAIN_DERIV_RST = 16'd0;
	localparam logic [15:0] TICK_LIMIT_RST = 16'd1000;
	localparam logic [7:0]  RIGHT_SCALE_RST = 8'd48;

	localparam logic [16:0] TICK_MAX = 17'h1ffff;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		STATUS_IDLE    = 2'd0,
		STATUS_RUNNING = 2'd1,
		STATUS_REACHED = 2'd2,
		STATUS_TIMEOUT = 2'd3
	} move_status_t;

	typedef enum logic [2:0] {
		CFG_GAIN_PROP             = 3'd0,
		CFG_GAIN_INTEGRAL_DIVISOR = 3'd1,
		CFG_GAIN_DERIV            = 3'd2,
		CFG_TICK_LIMIT            = 3'd3,
		CFG_RIGHT_TARGET_SCALE    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic               command;
		logic               move_right;
		logic [7:0]         target_byte;
		logic signed [15:0] count_a;
		logic signed [15:0] count_b;
		logic signed [15:0] count_c;
		logic signed [15:0] count_d;
	} in_item_t;

	typedef struct packed {
		logic [15:0] duty_a;
		logic [15:0] duty_b;
		logic [15:0] duty_c;
		logic [15:0] duty_d;
		logic [1:0]  move_status;
	} out_item_t;

	// sequencer to lane control group
	typedef struct packed {
		logic load;      // latch count, form error, arm divider
		logic div_step;  // one quotient bit
		logic mul;       // integral update and products
		logic commit;    // previous count takes current count
	} lane_ctl_t;

endpackage

@@ hdl/fwlp_lane.sv @@
// ----------------------------------------------------------------------------
// fwlp_lane - one wheel of the controller
// error, bit-serial integral division, derivative and proportional products
// ----------------------------------------------------------------------------
module fwlp_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  fwlp_pkg::lane_ctl_t ctl,
	input  logic signed [15:0]  count,
	input  logic                make_abs,
	input  logic signed [15:0]  target,
	input  logic [14:0]         divisor,
	input  logic [15:0]         gain_prop,
	input  logic [15:0]         gain_deriv,
	output logic [15:0]         duty,
	output logic                err_neg
);

	logic signed [15:0] curr_d;
	logic signed [17:0] err_d;
	logic [17:0]        err_neg_d;
	logic [15:0]        mag_d;
	logic [15:0]        rem_sh;
	logic               fits;
	logic [15:0]        rem_next;
	logic [31:0]        q_ext;
	logic [31:0]        q_signed;
	logic [15:0]        diff;
	logic [31:0]        prod_d;
	logic [31:0]        prod_p;

	logic signed [15:0] curr_q;
	logic signed [17:0] err_q;
	logic [15:0]        prev_q;
	logic [31:0]        integ_q;
	logic [15:0]        rem_q;
	logic [15:0]        quo_q;
	logic [15:0]        dterm_s1;
	logic [15:0]        pterm_s1;

	always_comb begin
		// absolute value when make_abs is set, most negative count saturates
		if (make_abs && count[15]) begin
			curr_d = (count == 16'sh8000) ? 16'sh7fff : -count;
		end else begin
			curr_d = count;
		end
		err_d     = $signed({{2{target[15]}}, target}) - $signed({{2{curr_d[15]}}, curr_d});
		err_neg_d = -err_d;
		mag_d     = err_d[17] ? err_neg_d[15:0] : err_d[15:0];
	end

	// restoring division, quotient shifts in where the dividend shifts out
	assign rem_sh   = {rem_q[14:0], quo_q[15]};
	assign fits     = rem_sh >= {1'b0, divisor};
	assign rem_next = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;

	// truncation toward zero: divide magnitudes, then restore the sign
	assign q_ext    = {16'b0, quo_q};
	assign q_signed = err_q[17] ? (32'd0 - q_ext) : q_ext;

	// only the low 16 bits of the drive survive, so low operand halves suffice
	assign diff   = curr_q - prev_q;
	assign prod_d = {16'b0, gain_deriv} * {16'b0, diff};
	assign prod_p = {16'b0, gain_prop} * {16'b0, err_q[15:0]};

	assign duty    = dterm_s1 + pterm_s1 + integ_q[15:0];
	assign err_neg = err_q[17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else begin
			if (ctl.mul) begin
				integ_q <= integ_q + q_signed;
			end
			if (ctl.commit) begin
				prev_q <= curr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			curr_q <= curr_d;
			err_q  <= err_d;
			quo_q  <= mag_d;
			rem_q  <= '0;
		end else if (ctl.div_step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[14:0], fits};
		end
		if (ctl.mul) begin
			dterm_s1 <= prod_d[15:0];
			pterm_s1 <= prod_p[15:0];
		end
	end

endmodule

@@ hdl/four_wheel_lateral_pid_move.sv @@
// ----------------------------------------------------------------------------
// four_wheel_lateral_pid_move - four channel position pid for lateral moves
// start transfers arm a move, tick transfers bring encoder counts and return
// four duties and the move status
// ----------------------------------------------------------------------------
// one input transfer gives exactly one output transfer. a start transfer or a
// tick outside a move or past the tick limit sets its result on acceptance and
// the done state hands it to the output register. a control tick latches the
// counts and errors on acceptance, runs the integral division (each wheel lane
// has its own restoring divider and makes one quotient bit a cycle), then does
// the integral update and the gain products, then the sum and the status
// decision, and then hands the result to the output register. while the output
// register stays stalled with a result ready to replace it, the result waits in
// the done state. the input is taken whenever the sequencer is idle, even while
// a finished result still waits in the output register. configuration is to be
// written through cfg_we, cfg_index and cfg_data only while the block is idle;
// the block does not enforce this. a zero integral divisor acts as one.
module four_wheel_lateral_pid_move (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fwlp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output fwlp_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_SUM,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] gain_prop_q;
	logic [14:0] gain_div_q;
	logic [15:0] gain_deriv_q;
	logic [15:0] tick_limit_q;
	logic [7:0]  right_scale_q;

	// move state
	logic signed [15:0] target_q;
	logic               dir_right_q;
	logic               moving_q;
	logic [16:0]        tick_q;

	logic [fwlp_pkg::STEP_W-1:0] step_q;
	fwlp_pkg::out_item_t         res_q;
	fwlp_pkg::out_item_t         out_q;
	logic                        out_valid_q;

	logic                accept;
	logic                tick_go;
	logic                reached;
	logic                out_free;
	logic [15:0]         scaled;
	logic [14:0]         div_eff;
	fwlp_pkg::lane_ctl_t ctl;

	logic signed [15:0] counts [fwlp_pkg::WHEELS];
	logic [15:0]        duties [fwlp_pkg::WHEELS];
	logic               err_negs [fwlp_pkg::WHEELS];

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// a tick that runs the full control law
	assign tick_go = accept && (in_item.command == fwlp_pkg::CMD_TICK) && moving_q
		&& !(tick_q > {1'b0, tick_limit_q});

	assign scaled  = {8'b0, in_item.target_byte} * {8'b0, right_scale_q};
	assign div_eff = (gain_div_q == '0) ? 15'd1 : gain_div_q;

	// the first wheel decides whether the target is passed
	assign reached = err_negs[0];

	always_comb begin
		ctl          = '0;
		ctl.load     = tick_go;
		ctl.div_step = (state_q == S_DIV);
		ctl.mul      = (state_q == S_MUL);
		ctl.commit   = (state_q == S_SUM) && !reached;
	end

	assign counts[0] = in_item.count_a;
	assign counts[1] = in_item.count_b;
	assign counts[2] = in_item.count_c;
	assign counts[3] = in_item.count_d;

	// one lane per wheel; left moves fold wheels b and d, right moves a and c
	for (genvar i = 0; i < fwlp_pkg::WHEELS; i++) begin : g_lane
		fwlp_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.count      (counts[i]),
			.make_abs   ((i % 2 == 0) ? dir_right_q : !dir_right_q),
			.target     (target_q),
			.divisor    (div_eff),
			.gain_prop  (gain_prop_q),
			.gain_deriv (gain_deriv_q),
			.duty       (duties[i]),
			.err_neg    (err_negs[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			gain_prop_q   <= fwlp_pkg::GAIN_PROP_RST;
			gain_div_q    <= fwlp_pkg::GAIN_DIV_RST;
			gain_deriv_q  <= fwlp_pkg::GAIN_DERIV_RST;
			tick_limit_q  <= fwlp_pkg::TICK_LIMIT_RST;
			right_scale_q <= fwlp_pkg::RIGHT_SCALE_RST;
			target_q      <= '0;
			dir_right_q   <= 1'b0;
			moving_q      <= 1'b0;
			tick_q        <= '0;
			step_q        <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					fwlp_pkg::CFG_GAIN_PROP:             gain_prop_q   <= cfg_data;
					fwlp_pkg::CFG_GAIN_INTEGRAL_DIVISOR: gain_div_q    <= cfg_data[14:0];
					fwlp_pkg::CFG_GAIN_DERIV:            gain_deriv_q  <= cfg_data;
					fwlp_pkg::CFG_TICK_LIMIT:            tick_limit_q  <= cfg_data;
					fwlp_pkg::CFG_RIGHT_TARGET_SCALE:    right_scale_q <= cfg_data[7:0];
					default: ;
				endcase
			end

			// output register empties on a completed transfer unless refilled below
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_item.command == fwlp_pkg::CMD_START) begin
							// new move: latch target and direction, restart tick count
							dir_right_q <= in_item.move_right;
							target_q    <= in_item.move_right ? scaled
								: {8'b0, in_item.target_byte};
							tick_q      <= '0;
							moving_q    <= 1'b1;
							res_q       <= {{fwlp_pkg::WHEELS{16'd0}},
								fwlp_pkg::STATUS_RUNNING};
							state_q     <= S_DONE;
						end else if (!moving_q) begin
							res_q       <= {{fwlp_pkg::WHEELS{16'd0}},
								fwlp_pkg::STATUS_IDLE};
							state_q     <= S_DONE;
						end else if (!tick_go) begin
							// tick count above the limit aborts the move
							moving_q    <= 1'b0;
							res_q       <= {{fwlp_pkg::WHEELS{16'd0}},
								fwlp_pkg::STATUS_TIMEOUT};
							state_q     <= S_DONE;
						end else begin
							res_q   <= '0;
							step_q  <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == fwlp_pkg::STEP_W'(fwlp_pkg::DIV_STEPS - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (reached) begin
						// integrals already updated, duties stay zero
						moving_q <= 1'b0;
						res_q.move_status <= fwlp_pkg::STATUS_REACHED;
					end else begin
						res_q.duty_a      <= duties[0];
						res_q.duty_b      <= duties[1];
						res_q.duty_c      <= duties[2];
						res_q.duty_d      <= duties[3];
						res_q.move_status <= fwlp_pkg::STATUS_RUNNING;
						if (tick_q != fwlp_pkg::TICK_MAX) begin
							tick_q <= tick_q + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// wait for room in the output register
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// a finished result reports running exactly when the move stays armed
	a_status_matches_move: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (moving_q == (res_q.move_status == fwlp_pkg::STATUS_RUNNING)))
		else $error("move status disagrees with move state");

	// the divider only starts on an accepted tick
	a_div_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_DIV) |-> $past(accept && in_item.command == fwlp_pkg::CMD_TICK))
		else $error("division started without an accepted tick");

	// the tick counter only goes down on a start transfer
	a_tick_clears_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q < $past(tick_q)) |-> $past(accept && in_item.command == fwlp_pkg::CMD_START))
		else $error("tick counter dropped outside a start");
`endif

endmodule

@@ bench/four_wheel_lateral_pid_move_tb.sv @@
// ----------------------------------------------------------------------------
// four_wheel_lateral_pid_move_tb - self-checking bench for the lateral pid move
// a queue-fed driver sends start and tick transfers with random gaps and
// stalls the result channel at random, a monitor checks every duty and status
// against a cycle-free model of the controller kept inside the bench
// ----------------------------------------------------------------------------
module four_wheel_lateral_pid_move_tb;

	timeunit 1ns;
	timeprecision 1ps;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	fwlp_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	fwlp_pkg::out_item_t out_item;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [15:0]         cfg_data;

	four_wheel_lateral_pid_move dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// transfers waiting to be sent, and the duties and status still owed
	fwlp_pkg::in_item_t  move_items[$];
	fwlp_pkg::out_item_t expected_drive[$];
	int        errors = 0;
	logic      calm = 1'b0;      // no idling on either side while set
	logic      in_taken = 1'b0;  // input transfer happened at the last rising edge

	// controller registers as the block holds them
	shortint         kp = 1;
	logic [14:0]     kdiv = 15'd1;
	shortint         kd = 0;
	logic [15:0]     tlimit = 16'd1000;
	logic [7:0]      rscale = 8'd48;

	// controller state
	shortint         target = 0;
	logic            dir_right = 1'b0;
	logic            moving = 1'b0;
	shortint         prev_count[fwlp_pkg::WHEELS] = '{default: 0};
	int              integ[fwlp_pkg::WHEELS] = '{default: 0};
	logic [16:0]     ticks = '0;

	// one transfer through the controller: updates the state, returns the result
	function automatic fwlp_pkg::out_item_t control_step(input fwlp_pkg::in_item_t it);
		fwlp_pkg::out_item_t r;
		int          raw[fwlp_pkg::WHEELS];
		int          cur[fwlp_pkg::WHEELS];
		int          err[fwlp_pkg::WHEELS];
		logic [15:0] duty[fwlp_pkg::WHEELS];
		logic [15:0] prod;
		longint      drive;
		int          dvs;
		logic        flip;
		r = '0;
		duty = '{default: '0};
		raw[0] = int'(shortint'(it.count_a));
		raw[1] = int'(shortint'(it.count_b));
		raw[2] = int'(shortint'(it.count_c));
		raw[3] = int'(shortint'(it.count_d));
		if (it.command == fwlp_pkg::CMD_START) begin
			dir_right = it.move_right;
			prod = 16'(it.target_byte) * 16'(rscale);
			target = dir_right ? shortint'(prod) : shortint'({8'd0, it.target_byte});
			ticks = '0;
			moving = 1'b1;
			r.move_status = fwlp_pkg::STATUS_RUNNING;
			return r;
		end
		if (!moving) begin
			r.move_status = fwlp_pkg::STATUS_IDLE;
			return r;
		end
		if (ticks > {1'b0, tlimit}) begin
			moving = 1'b0;
			r.move_status = fwlp_pkg::STATUS_TIMEOUT;
			return r;
		end
		// the wheels turning backwards for this direction are folded to positive
		for (int i = 0; i < fwlp_pkg::WHEELS; i++) begin
			flip = dir_right ? (i % 2 == 0) : (i % 2 == 1);
			cur[i] = raw[i];
			if (flip && raw[i] < 0)
				cur[i] = (raw[i] == -32768) ? 32767 : -raw[i];
		end
		dvs = (kdiv == 0) ? 1 : int'(kdiv);
		for (int i = 0; i < fwlp_pkg::WHEELS; i++) begin
			err[i] = int'(target) - cur[i];
			integ[i] = integ[i] + err[i] / dvs;
		end
		// first wheel past the target ends the move, integrals already taken
		if (err[0] < 0) begin
			moving = 1'b0;
			r.move_status = fwlp_pkg::STATUS_REACHED;
			return r;
		end
		for (int i = 0; i < fwlp_pkg::WHEELS; i++) begin
			drive = longint'(kd) * longint'(cur[i] - int'(prev_count[i]))
				+ longint'(kp) * longint'(err[i]) + longint'(integ[i]);
			duty[i] = drive[15:0];
			prev_count[i] = shortint'(cur[i]);
		end
		if (ticks != fwlp_pkg::TICK_MAX)
			ticks = ticks + 17'd1;
		r.duty_a = duty[0];
		r.duty_b = duty[1];
		r.duty_c = duty[2];
		r.duty_d = duty[3];
		r.move_status = fwlp_pkg::STATUS_RUNNING;
		return r;
	endfunction

	function automatic fwlp_pkg::in_item_t mk(input fwlp_pkg::command_t cmd,
			input logic right, input logic [7:0] tb, input shortint a,
			input shortint b, input shortint c, input shortint d);
		fwlp_pkg::in_item_t it;
		it.command = cmd;
		it.move_right = right;
		it.target_byte = tb;
		it.count_a = a;
		it.count_b = b;
		it.count_c = c;
		it.count_d = d;
		return it;
	endfunction

	// any transfer at all, every bit free
	function automatic fwlp_pkg::in_item_t rand_item();
		return mk(fwlp_pkg::command_t'($urandom_range(1)), 1'($urandom_range(1)),
			8'($urandom_range(255)), shortint'($urandom), shortint'($urandom),
			shortint'($urandom), shortint'($urandom));
	endfunction

	// one move: a start, then ticks, most with the wheels creeping towards the target
	task automatic queue_move(input int n_ticks);
		logic       right;
		logic [7:0] tb;
		int         goal;
		int         pos;
		int         step;
		int         v[fwlp_pkg::WHEELS];
		right = 1'($urandom_range(1));
		tb = 8'($urandom_range(255));
		goal = right ? int'(shortint'(16'(tb) * 16'(rscale))) : int'(tb);
		move_items.push_back(mk(fwlp_pkg::CMD_START, right, tb, shortint'($urandom),
			shortint'($urandom), shortint'($urandom), shortint'($urandom)));
		pos = int'($urandom_range(6)) - 3;
		step = (goal < 0 ? -goal : goal) / int'($urandom_range(3, 15)) + 1;
		for (int k = 0; k < n_ticks; k++) begin
			if ($urandom_range(19) == 0) begin
				move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'($urandom_range(1)),
					8'($urandom_range(255)), shortint'($urandom), shortint'($urandom),
					shortint'($urandom), shortint'($urandom)));
			end else begin
				pos += int'($urandom_range(step));
				for (int i = 0; i < fwlp_pkg::WHEELS; i++) begin
					v[i] = pos + int'($urandom_range(16)) - 8;
					// backwards wheels mostly report negative counts
					if (((i % 2 == 0) == right) && $urandom_range(3) != 0)
						v[i] = -v[i];
				end
				move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'($urandom_range(1)),
					8'($urandom_range(255)), shortint'(v[0]), shortint'(v[1]),
					shortint'(v[2]), shortint'(v[3])));
			end
		end
	endtask

	// register writes, only with the block idle
	task automatic configure(input logic [15:0] p, input logic [15:0] dv,
			input logic [15:0] dr, input logic [15:0] lim, input logic [7:0] sc);
		logic [15:0]        vals[5];
		fwlp_pkg::cfg_reg_t regs[5];
		vals = '{p, dv, dr, lim, {8'd0, sc}};
		regs = '{fwlp_pkg::CFG_GAIN_PROP, fwlp_pkg::CFG_GAIN_INTEGRAL_DIVISOR,
			fwlp_pkg::CFG_GAIN_DERIV, fwlp_pkg::CFG_TICK_LIMIT,
			fwlp_pkg::CFG_RIGHT_TARGET_SCALE};
		for (int i = 0; i < 5; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		kp = shortint'(p);
		kdiv = dv[14:0];
		kd = shortint'(dr);
		tlimit = lim;
		rscale = sc;
	endtask

	// waits until every queued transfer is sent and every owed result is back, then lets the clock run on
	task automatic settle();
		while (move_items.size() != 0 || expected_drive.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_val(input logic [15:0] lo,
			input logic [15:0] hi);
		case ($urandom_range(3))
			0: return lo;
			1: return hi;
			2: return 16'(int'($urandom_range(40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, name,
				exp_v, act_v);
		end
	endtask

	// driver: a new transfer is offered once the last one was taken
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (move_items.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
				in_item <= move_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
	end

	// input side: every accepted transfer goes through the model
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_drive.push_back(control_step(in_item));
			in_taken <= 1'b1;
		end else begin
			in_taken <= 1'b0;
		end
	end

	// result side: field by field against the oldest expectation
	always @(posedge clk) begin
		fwlp_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_drive.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, expected none actual %h", $time,
					out_item);
			end else begin
				want = expected_drive.pop_front();
				check_field("duty_a", want.duty_a, out_item.duty_a);
				check_field("duty_b", want.duty_b, out_item.duty_b);
				check_field("duty_c", want.duty_c, out_item.duty_c);
				check_field("duty_d", want.duty_d, out_item.duty_d);
				check_field("move_status", 16'(want.move_status),
					16'(out_item.move_status));
			end
		end
	end

	initial begin
		int count;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = fwlp_pkg::CFG_GAIN_PROP;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: idle tick, saturating fold, reached, restart mid move
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 32767, -32768, 0, -1));
		move_items.push_back(mk(fwlp_pkg::CMD_START, 1'b0, 8'd255, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 0, -32768, 32767, -1));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 100, -100, 100, -100));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, -32768, 5, -5, 5));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 256, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 1, 1, 1, 1));
		move_items.push_back(mk(fwlp_pkg::CMD_START, 1'b1, 8'd255, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b1, 8'd0, -32768, -1, -32768, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_START, 1'b1, 8'd0, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, -1, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_START, 1'b0, 8'd0, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_START, 1'b0, 8'd128, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 10, 20, 30, 40));
		settle();

		// gain extremes, zero divisor, zero tick limit, negative right target
		configure(16'h7fff, 16'h0000, 16'h8000, 16'h0000, 8'd255);
		move_items.push_back(mk(fwlp_pkg::CMD_START, 1'b1, 8'd255, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_START, 1'b0, 8'd200, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 1, 2, 3, 4));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 5, 6, 7, 8));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b0, 8'd0, 9, 9, 9, 9));
		settle();

		// opposite extremes, divisor top bit dropped, zero right scale
		configure(16'h8000, 16'hffff, 16'h7fff, 16'hffff, 8'd0);
		move_items.push_back(mk(fwlp_pkg::CMD_START, 1'b1, 8'd77, 0, 0, 0, 0));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b1, 8'hff, 0, 32767, -32768,
			12345));
		move_items.push_back(mk(fwlp_pkg::CMD_TICK, 1'b1, 8'hff, -5, -32768, 32767,
			-32768));
		settle();

		// random moves, a fresh register setting for each phase
		for (int ph = 0; ph < 8; ph++) begin
			configure(pick_val(16'h8000, 16'h7fff), pick_val(16'h0000, 16'h7fff),
				pick_val(16'h8000, 16'h7fff),
				($urandom_range(3) == 0) ? pick_val(16'h0000, 16'hffff)
					: 16'($urandom_range(2, 40)),
				($urandom_range(2) == 0) ? 8'($urandom_range(255))
					: (($urandom_range(1) == 1) ? 8'd255 : 8'd48));
			calm = (ph == 2);
			count = 0;
			while (count < 190) begin
				if ($urandom_range(9) == 0) begin
					move_items.push_back(rand_item());
					count++;
				end else begin
					int n = $urandom_range(1, 25);
					queue_move(n);
					count += n + 1;
				end
			end
			settle();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ four_wheel_lateral_pid_move.f @@
hdl/fwlp_pkg.sv
hdl/fwlp_lane.sv
hdl/four_wheel_lateral_pid_move.sv
bench/four_wheel_lateral_pid_move_tb.sv
